// ----- rtl/srde_pkg.sv -----
// Shared constants, types and the digit-to-ASCII mapping for the radix encoder.
// No dependencies; imported by srde_divider and signed_radix_digit_encoder.
package srde_pkg;

    localparam int DEFAULT_WIDTH = 32;   // integer width converted
    localparam int VALUE_W       = 32;   // width of the value port
    localparam int RADIX_W       = 6;
    localparam int DIGIT_W       = 6;    // one digit, 0..35
    localparam int CHAR_W        = 8;
    localparam int DIV_STEP      = 8;    // quotient bits retired per divider cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

    typedef struct packed {
        logic               done;    // one-cycle pulse: quotient and digit ready
        logic [DIGIT_W-1:0] digit;   // remainder of the division
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] dx;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        dx   = CHAR_W'(d);
        if (d >= DEC_DIGITS)
            digit_char = base + dx - CHAR_W'(DEC_DIGITS);
        else
            digit_char = CHAR_ZERO + dx;
    endfunction

endpackage

// ----- rtl/srde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/srde_divider.sv -----
// Iterative divider by a 6-bit radix: restoring division, DIV_STEP quotient bits per cycle.
// Depends on srde_pkg.
module srde_divider
    import srde_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [WIDTH-1:0]   dividend,
    input  logic [RADIX_W-1:0] divisor,   // held stable while busy
    output logic [WIDTH-1:0]   quotient,
    output div_status_t        status
);

    localparam int CYC  = (WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int PADW = CYC * DIV_STEP;
    localparam int CW   = (CYC > 1) ? $clog2(CYC) : 1;

    logic [PADW-1:0]    acc_reg, acc_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg, done_reg;
    logic [DIV_STEP-1:0] qbits;

    // Shared step unit: DIV_STEP dependent narrow compare/subtract steps.
    always_comb
    begin
        logic [DIGIT_W:0] trial;
        logic [DIGIT_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        trial = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {r, acc_reg[PADW-1-i]};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
                qbits[DIV_STEP-1-i] = 1'b1;
            end
            r = trial[DIGIT_W-1:0];
        end
        rem_next = r;
        acc_next = (acc_reg << DIV_STEP) | PADW'(qbits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(CYC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= PADW'(dividend);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient     = acc_reg[WIDTH-1:0];
    assign status.done  = done_reg;
    assign status.digit = rem_reg;

endmodule

// ----- rtl/signed_radix_digit_encoder.sv -----
// Integer to ASCII converter, radix 2..36, top level.
// Depends on srde_pkg, srde_divider and srde_ram.

// One transfer on the item channel carries an integer (low WIDTH bits of
// value, signed when op = 1), a radix and a letter case; the result channel
// then gives the ASCII string most significant first: a leading '-' for a
// negative signed value, then the digits, with last set on the final one.
// A radix outside 2..36 gives one result with character 0, last 1 and
// bad_radix 1. The block takes one item at a time and item_ready is low
// until the final character has been transferred. The divider
// retires 8 quotient bits per cycle and gives one digit per division;
// each digit character then passes through the digit RAM read and the
// output register, and the sign through the output register alone.
module signed_radix_digit_encoder
    import srde_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               op,
    input  logic [VALUE_W-1:0] value,
    input  logic [RADIX_W-1:0] radix,
    input  logic               upper_case,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic [CHAR_W-1:0]  character,
    output logic               last,
    output logic               bad_radix
);

    localparam int CNT_W = $clog2(WIDTH + 1);   // digit count, 0..WIDTH
    localparam int AW    = $clog2(WIDTH);       // digit RAM address
    localparam int EXT_W = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,  // waiting for an item
        ST_DIV  = 6'b000010,  // repeated division, one digit per pass
        ST_SIGN = 6'b000100,  // load the minus sign
        ST_READ = 6'b001000,  // address the next digit in the RAM
        ST_LOAD = 6'b010000,  // RAM data into the output register
        ST_OUT  = 6'b100000   // result held until transferred
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               upper_reg, upper_next;
    logic [CHAR_W-1:0]  character_reg, character_next;
    logic               last_reg, last_next;
    logic               bad_radix_reg, bad_radix_next;

    // Input decode
    logic [EXT_W-1:0] value_ext;
    logic [WIDTH-1:0] v_in, mag_in;
    logic             neg_in, radix_bad, item_xfer;

    assign value_ext = EXT_W'(value);
    assign v_in      = value_ext[WIDTH-1:0];
    assign neg_in    = op & v_in[WIDTH-1];
    // Two's complement modulo 2^WIDTH: the most negative value maps to itself,
    // which is the correct unsigned magnitude.
    assign mag_in    = neg_in ? (~v_in + 1'b1) : v_in;
    assign radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    assign item_xfer = item_valid && item_ready;

    // Divider and digit store
    logic               div_start;
    logic [WIDTH-1:0]   div_dividend, div_quotient;
    div_status_t        div_status;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [DIGIT_W-1:0] ram_rdata;
    logic [CNT_W-1:0]   count_inc, count_dec;

    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign ram_raddr = count_dec[AW-1:0];

    // Next dividend: fresh magnitude on accept, running quotient otherwise.
    assign div_dividend = state_reg[0] ? mag_in : div_quotient;

    srde_divider #(
        .WIDTH(WIDTH)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (radix_reg),
        .quotient(div_quotient),
        .status  (div_status)
    );

    srde_ram #(
        .DATA_W(DIGIT_W),
        .DEPTH (WIDTH)
    ) u_digit_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(div_status.digit),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        radix_next     = radix_reg;
        upper_next     = upper_reg;
        character_next = character_reg;
        last_next      = last_reg;
        bad_radix_next = bad_radix_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    if (radix_bad)
                    begin
                        // single error result, conversion state untouched
                        character_next = CHAR_NONE;
                        last_next      = 1'b1;
                        bad_radix_next = 1'b1;
                        state_next     = ST_OUT;
                    end
                    else
                    begin
                        neg_next   = neg_in;
                        radix_next = radix;
                        upper_next = upper_case;
                        count_next = '0;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_status.done)
                begin
                    ram_we     = 1'b1;
                    count_next = count_inc;
                    if ((div_quotient == '0) || (count_inc == CNT_W'(WIDTH)))
                        state_next = neg_reg ? ST_SIGN : ST_READ;
                    else
                        div_start = 1'b1;
                end
            end

            ST_SIGN:
            begin
                character_next = CHAR_MINUS;
                last_next      = 1'b0;
                bad_radix_next = 1'b0;
                state_next     = ST_OUT;
            end

            ST_READ:
            begin
                count_next = count_dec;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                character_next = digit_char(ram_rdata, upper_reg);
                last_next      = (count_reg == '0);
                bad_radix_next = 1'b0;
                state_next     = ST_OUT;
            end

            ST_OUT:
            begin
                if (result_ready)
                    state_next = last_reg ? ST_IDLE : ST_READ;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            radix_reg <= '0;
            upper_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            upper_reg <= upper_next;
        end
    end

    // Output payload register, no reset needed
    always_ff @(posedge clk)
    begin
        character_reg <= character_next;
        last_reg      <= last_next;
        bad_radix_reg <= bad_radix_next;
    end

    assign item_ready   = state_reg[0];
    assign result_valid = state_reg[5];
    assign character    = character_reg;
    assign last         = last_reg;
    assign bad_radix    = bad_radix_reg;

    // Assertions
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item_ready and result_valid both high");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WIDTH))
        else $error("digit count beyond WIDTH");

    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && radix_bad) |=> (result_valid && bad_radix && last))
        else $error("bad radix did not yield a single error result");

    a_bad_char: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_radix) |-> (character == CHAR_NONE))
        else $error("error result carries a character");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

endmodule
